FILE: rtl/tpsv_pkg.sv
// Package with the types and constants of the triple-redundant parameter store.
package tpsv_pkg;

    localparam int TABLE_BYTES = 6;
    localparam int TABLE_W     = 8 * TABLE_BYTES;
    localparam int CFG_IDX_W   = 1;

    localparam logic [7:0] ERR_VALUE    = 8'hFF;
    localparam logic [7:0] ERASED_VALUE = 8'hFF;
    localparam logic [7:0] NO_MAX       = 8'hFF;
    localparam logic [7:0] NO_DEFAULT   = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TABLE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TABLE = 1'b1;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_LOAD  = 2'd1,
        OP_RAW   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REP_NONE  = 2'd0,
        REP_COPY0 = 2'd1,
        REP_COPY1 = 2'd2,
        REP_COPY2 = 2'd3
    } rep_t;

    typedef struct packed {
        op_t        operation;
        logic [3:0] index;
        logic [7:0] value;
        logic [1:0] copy_select;
    } req_t;

    typedef struct packed {
        logic [7:0] result_value;
        rep_t       repaired_copy;
        logic       was_clamped;
        logic       index_error;
    } rsp_t;

    // Byte k of a packed table; indices past the table give the fallback byte.
    function automatic logic [7:0] table_byte(input logic [TABLE_W-1:0] tbl,
                                              input logic [3:0] k,
                                              input logic [7:0] beyond);
        logic [7:0] b;
        b = beyond;
        for (int i = 0; i < TABLE_BYTES; i++)
        begin
            if (k == 4'(i))
            begin
                b = tbl[8*i +: 8];
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/tpsv_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
interface tpsv_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/tmr_parameter_store_voter_unit.sv
// Triple-redundant parameter store: voted, clamped load with repair, clamped store, raw test write.
//
// Usage: requests arrive on the req stream (operation, index, value, copy_select)
// and every accepted beat yields exactly one beat on the rsp stream, in order.
// A request is first captured in an input register; when it advances, the
// vote, repair, clamp and copy update are done in one pass and the answer is
// placed in the output register. One item is taken per cycle for as long as
// rsp is drained. When the receiver stalls, the output register holds its beat
// and the input register can still take one more request; after that req.ready
// drops. The two table registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce it. Reset sets every byte of the three copies to 0xFF, the
// maximum table to all ones and the default table to zero, and empties both
// pipeline registers.
module tmr_parameter_store_voter_unit
    import tpsv_pkg::*;
#(
    parameter int PARAM_COUNT = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TABLE_W-1:0]   cfg_data,
    tpsv_stream_if.sink          req,
    tpsv_stream_if.source        rsp
);

    localparam int IDX_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

    logic [TABLE_W-1:0] max_reg;
    logic [TABLE_W-1:0] default_reg;
    logic [7:0]         copy0_reg [PARAM_COUNT];
    logic [7:0]         copy1_reg [PARAM_COUNT];
    logic [7:0]         copy2_reg [PARAM_COUNT];

    req_t req_reg;
    logic req_valid_reg;
    rsp_t rsp_reg;
    logic rsp_valid_reg;

    logic       advance;
    logic       idx_ok;
    logic [IDX_W-1:0] addr;
    logic [7:0] a, b, c;
    logic [7:0] max_b, def_b, def0;
    logic [7:0] voted, forced;
    logic       zero_hit, over;
    logic       wr0, wr1, wr2;
    logic [7:0] d0, d1, d2;
    rsp_t       rsp_next;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    assign idx_ok = req_reg.index < 4'(PARAM_COUNT);
    assign addr   = req_reg.index[IDX_W-1:0];
    assign a      = copy0_reg[addr];
    assign b      = copy1_reg[addr];
    assign c      = copy2_reg[addr];
    assign max_b  = table_byte(max_reg, req_reg.index, NO_MAX);
    assign def_b  = table_byte(default_reg, req_reg.index, NO_DEFAULT);
    assign def0   = table_byte(default_reg, 4'd0, NO_DEFAULT);

    always_comb
    begin
        rsp_next.result_value  = ERR_VALUE;
        rsp_next.repaired_copy = REP_NONE;
        rsp_next.was_clamped   = 1'b0;
        rsp_next.index_error   = 1'b0;
        wr0 = 1'b0;
        wr1 = 1'b0;
        wr2 = 1'b0;
        d0 = req_reg.value;
        d1 = req_reg.value;
        d2 = req_reg.value;
        voted = b;
        forced = b;
        zero_hit = 1'b0;
        over = 1'b0;

        if (req_reg.operation == OP_NONE)
        begin
            rsp_next.result_value = ERR_VALUE;
        end
        else if (!idx_ok)
        begin
            rsp_next.index_error = 1'b1;
        end
        else
        begin
            unique case (req_reg.operation)
                OP_STORE:
                begin
                    over = req_reg.value > max_b;
                    rsp_next.result_value = over ? def_b : req_reg.value;
                    rsp_next.was_clamped  = over;
                    d0 = rsp_next.result_value;
                    d1 = rsp_next.result_value;
                    d2 = rsp_next.result_value;
                    wr0 = 1'b1;
                    wr1 = 1'b1;
                    wr2 = 1'b1;
                end
                OP_LOAD:
                begin
                    // With no two copies agreeing, copy one is trusted.
                    if (a == b)
                    begin
                        voted = a;
                        if (b != c)
                        begin
                            wr2 = 1'b1;
                            rsp_next.repaired_copy = REP_COPY2;
                        end
                    end
                    else if (a == c)
                    begin
                        voted = a;
                        wr1 = 1'b1;
                        rsp_next.repaired_copy = REP_COPY1;
                    end
                    else
                    begin
                        voted = b;
                        wr0 = 1'b1;
                        rsp_next.repaired_copy = REP_COPY0;
                    end
                    d0 = voted;
                    d1 = voted;
                    d2 = voted;
                    zero_hit = (req_reg.index == 4'd0) && (voted == 8'd0);
                    forced = zero_hit ? def0 : voted;
                    over = forced > max_b;
                    rsp_next.result_value = over ? def_b : forced;
                    rsp_next.was_clamped  = zero_hit || over;
                end
                OP_RAW:
                begin
                    wr0 = req_reg.copy_select == 2'd0;
                    wr1 = req_reg.copy_select == 2'd1;
                    wr2 = req_reg.copy_select == 2'd2;
                    rsp_next.result_value = req_reg.value;
                end
                default:
                begin
                    rsp_next.result_value = ERR_VALUE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg     <= {TABLE_W{1'b1}};
            default_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_TABLE:     max_reg     <= cfg_data;
                CFG_DEFAULT_TABLE: default_reg <= cfg_data;
                default:           max_reg     <= max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PARAM_COUNT; i++)
            begin
                copy0_reg[i] <= ERASED_VALUE;
                copy1_reg[i] <= ERASED_VALUE;
                copy2_reg[i] <= ERASED_VALUE;
            end
        end
        else if (advance)
        begin
            if (wr0)
            begin
                copy0_reg[addr] <= d0;
            end
            if (wr1)
            begin
                copy1_reg[addr] <= d1;
            end
            if (wr2)
            begin
                copy2_reg[addr] <= d2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.payload;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
